FILE: sv/assert_macros.svh
// Assertion macros used by the sequencer of the cluster chain allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FCCA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define FCCA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: sv/fcca_pkg.sv
// Package with the shared constants and types of the cluster chain allocator.
`default_nettype none

package fcca_pkg;

	localparam int TABLE_ENTRIES_DEF = 4096;
	localparam int CLUSTER_BYTES_DEF = 512;

	localparam int LINK_W = 13;
	localparam int SIZE_W = 22;
	localparam int START_W = 12;
	localparam int CNT_W = 12;

	localparam logic [LINK_W-1:0] END_MARK = '1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	localparam logic STAT_DONE = 1'b0;
	localparam logic STAT_NO_SPACE = 1'b1;

	typedef struct packed {
		logic status;
		logic [LINK_W-1:0] first_cluster;
		logic [CNT_W-1:0] clusters_free;
	} fcca_res_t;

endpackage

`default_nettype wire

FILE: sv/fcca_ram.sv
// Link table memory: one write port, one read port, registered read data.
`default_nettype none

module fcca_ram #(
	parameter int DEPTH = fcca_pkg::TABLE_ENTRIES_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [fcca_pkg::LINK_W-1:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [fcca_pkg::LINK_W-1:0] rdata
);

	logic [fcca_pkg::LINK_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// A read of the entry being written in the same cycle returns the new value.
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/fcca_ctrl.sv
// Sequencer that clears, scans and walks the link table and counts free clusters.
`default_nettype none

module fcca_ctrl #(
	parameter int TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF,
	parameter int CLUSTER_BYTES = fcca_pkg::CLUSTER_BYTES_DEF,
	parameter int AW = $clog2(TABLE_ENTRIES)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire logic command,
	input wire logic [fcca_pkg::SIZE_W-1:0] size_bytes,
	input wire logic [fcca_pkg::START_W-1:0] start_cluster,
	output logic res_valid,
	input wire logic res_ready,
	output fcca_pkg::fcca_res_t res,
	output logic mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [fcca_pkg::LINK_W-1:0] mem_wdata,
	output logic mem_re,
	output logic [AW-1:0] mem_raddr,
	input wire logic [fcca_pkg::LINK_W-1:0] mem_rdata
);

	`include "assert_macros.svh"

	localparam int CB_W = $clog2(CLUSTER_BYTES + 1);
	localparam int PW = fcca_pkg::CNT_W + CB_W;
	localparam int CMPW = (PW > fcca_pkg::SIZE_W) ? PW : fcca_pkg::SIZE_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
	localparam logic [fcca_pkg::LINK_W-1:0] TE_LINK = fcca_pkg::LINK_W'(TABLE_ENTRIES);
	localparam logic [fcca_pkg::SIZE_W-1:0] CB_SIZE = fcca_pkg::SIZE_W'(CLUSTER_BYTES);
	localparam logic [fcca_pkg::CNT_W-1:0] FREE_RESET = fcca_pkg::CNT_W'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {
		CLEAR,
		IDLE,
		CHECK,
		DECIDE,
		SCAN,
		TAIL,
		WSTART,
		WALK
	} state_t;

	state_t state_q;
	logic resp_q;
	logic [AW-1:0] clr_q;
	logic [fcca_pkg::SIZE_W-1:0] size_q;
	logic [fcca_pkg::START_W-1:0] start_q;
	logic [fcca_pkg::SIZE_W-1:0] rem_q;
	logic [PW-1:0] prod_q;
	logic [fcca_pkg::CNT_W-1:0] free_q;
	logic status_q;
	logic [fcca_pkg::LINK_W-1:0] first_q;
	logic [AW-1:0] scan_q;
	logic scan_done_q;
	logic rd_v_s1;
	logic [AW-1:0] rd_addr_s1;
	logic [AW-1:0] prev_q;
	logic have_prev_q;
	logic [AW-1:0] cur_q;

	logic claim;
	logic last_claim;
	logic scan_end;
	logic start_ok;
	logic walk_hit;
	logic walk_cont;

	assign claim = rd_v_s1 && (mem_rdata == '0);
	assign last_claim = claim && (rem_q <= CB_SIZE);
	assign scan_end = last_claim || (rd_v_s1 && (rd_addr_s1 == LAST_IDX));
	assign start_ok = (start_q != '0)
		&& ({1'b0, start_q} < TE_LINK);
	assign walk_hit = (mem_rdata != '0);
	assign walk_cont = walk_hit && (mem_rdata != fcca_pkg::END_MARK)
		&& (mem_rdata < TE_LINK);

	assign cmd_ready = (state_q == IDLE) && !resp_q;
	assign res_valid = resp_q;
	assign res.status = status_q;
	assign res.first_cluster = first_q;
	assign res.clusters_free = free_q;

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = prev_q;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = scan_q;
		case (state_q)
			CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q == '0) ? fcca_pkg::END_MARK : '0;
			end
			SCAN: begin
				mem_re = !scan_done_q && !scan_end;
				if (claim && have_prev_q) begin
					mem_we = 1'b1;
					mem_wdata = fcca_pkg::LINK_W'(rd_addr_s1);
				end
			end
			TAIL: begin
				mem_we = 1'b1;
				mem_wdata = fcca_pkg::END_MARK;
			end
			WSTART: begin
				mem_re = start_ok;
				mem_raddr = start_q[AW-1:0];
			end
			WALK: begin
				mem_we = walk_hit;
				mem_waddr = cur_q;
				mem_re = walk_cont;
				mem_raddr = mem_rdata[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			resp_q <= 1'b0;
			clr_q <= '0;
			free_q <= FREE_RESET;
			rd_v_s1 <= 1'b0;
			scan_done_q <= 1'b0;
			have_prev_q <= 1'b0;
		end else begin
			case (state_q)
				CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (resp_q) begin
						if (res_ready) begin
							resp_q <= 1'b0;
						end
					end else if (cmd_valid) begin
						size_q <= size_bytes;
						start_q <= start_cluster;
						status_q <= fcca_pkg::STAT_DONE;
						first_q <= fcca_pkg::END_MARK;
						state_q <= (command == fcca_pkg::CMD_FREE) ? WSTART : CHECK;
					end
				end
				CHECK: begin
					prod_q <= PW'(free_q) * PW'(CLUSTER_BYTES);
					state_q <= DECIDE;
				end
				DECIDE: begin
					if (size_q == '0) begin
						resp_q <= 1'b1;
						state_q <= IDLE;
					end else if (CMPW'(size_q) > CMPW'(prod_q)) begin
						status_q <= fcca_pkg::STAT_NO_SPACE;
						resp_q <= 1'b1;
						state_q <= IDLE;
					end else begin
						rem_q <= size_q;
						scan_q <= AW'(1);
						scan_done_q <= 1'b0;
						rd_v_s1 <= 1'b0;
						have_prev_q <= 1'b0;
						state_q <= SCAN;
					end
				end
				SCAN: begin
					// No read is issued once the scan ends, so the pipeline empties by itself.
					rd_v_s1 <= mem_re;
					rd_addr_s1 <= scan_q;
					if (mem_re) begin
						scan_q <= scan_q + 1'b1;
						if (scan_q == LAST_IDX) begin
							scan_done_q <= 1'b1;
						end
					end
					if (claim) begin
						if (!have_prev_q) begin
							first_q <= fcca_pkg::LINK_W'(rd_addr_s1);
						end
						prev_q <= rd_addr_s1;
						have_prev_q <= 1'b1;
						free_q <= free_q - 1'b1;
						rem_q <= rem_q - CB_SIZE;
					end
					if (scan_end) begin
						if (claim || have_prev_q) begin
							state_q <= TAIL;
						end else begin
							resp_q <= 1'b1;
							state_q <= IDLE;
						end
					end
				end
				TAIL: begin
					resp_q <= 1'b1;
					state_q <= IDLE;
				end
				WSTART: begin
					cur_q <= start_q[AW-1:0];
					if (start_ok) begin
						state_q <= WALK;
					end else begin
						resp_q <= 1'b1;
						state_q <= IDLE;
					end
				end
				WALK: begin
					if (walk_hit) begin
						free_q <= free_q + 1'b1;
					end
					if (walk_cont) begin
						cur_q <= mem_rdata[AW-1:0];
					end else begin
						resp_q <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	`FCCA_NEVER(a_free_in_range, free_q > FREE_RESET, "free count above table capacity")
	`FCCA_ASSERT(a_link_behind_scan, (state_q == SCAN && mem_we) |-> (mem_waddr < rd_addr_s1),
		"link write not behind scan position")
	`FCCA_ASSERT(a_claim_counts, (state_q == SCAN && claim) |=> (free_q == $past(free_q) - 1'b1),
		"claimed cluster not counted")
	`FCCA_ASSERT(a_reserved_kept, (mem_we && mem_waddr == '0) |-> (state_q == CLEAR),
		"reserved entry written outside clearing pass")

endmodule

`default_nettype wire

FILE: sv/fat_cluster_chain_allocator.sv
// Allocate: space check, then a scan from entry 1, skipped when refused or size zero.
// Free: one table read and one write per step of the walk.
// The scan and the walk both go through the single read port of the link table.
// One transaction is worked on at a time; a result waits in the output register.
// After reset a clearing pass initializes the table, with cmd_ready low.
// Reset is asynchronous and active low; it clears the sequencer state, the valid flags and the free count.
`default_nettype none

module fat_cluster_chain_allocator #(
	parameter int TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF,
	parameter int CLUSTER_BYTES = fcca_pkg::CLUSTER_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire logic command,
	input wire logic [fcca_pkg::SIZE_W-1:0] size_bytes,
	input wire logic [fcca_pkg::START_W-1:0] start_cluster,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output logic status,
	output logic signed [fcca_pkg::LINK_W-1:0] first_cluster,
	output logic [fcca_pkg::CNT_W-1:0] clusters_free
);

	localparam int AW = $clog2(TABLE_ENTRIES);

	// Memory port between the sequencer and the link table.
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [fcca_pkg::LINK_W-1:0] mem_wdata;
	logic mem_re;
	logic [AW-1:0] mem_raddr;
	logic [fcca_pkg::LINK_W-1:0] mem_rdata;

	// Finished result offered by the sequencer.
	logic res_valid;
	logic res_ready;
	fcca_pkg::fcca_res_t res;

	fcca_ram #(
		.DEPTH(TABLE_ENTRIES),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	fcca_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.CLUSTER_BYTES(CLUSTER_BYTES),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.command(command),
		.size_bytes(size_bytes),
		.start_cluster(start_cluster),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// The output register takes a new result whenever it is empty or being drained,
	// so the sequencer can go back to accepting commands while a result waits.
	assign res_ready = !rsp_valid || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	// Payload registers load only on a transfer from the sequencer.
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			status <= res.status;
			first_cluster <= res.first_cluster;
			clusters_free <= res.clusters_free;
		end
	end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the FAT cluster chain allocator: directed table, then random traffic.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fcca_pkg::*;

	// The block is built with its default table size and cluster size, and the mirror below
	// uses the same numbers.
	localparam int N_ENTRIES = TABLE_ENTRIES_DEF;
	localparam int BYTES_PER_CLUSTER = CLUSTER_BYTES_DEF;
	localparam logic [LINK_W-1:0] FREE_LINK = '0;

	// Directed rows come first; the random part follows, with a quiet tail and no idling.
	localparam int RANDOM_OPS = 113;
	localparam int QUIET_TAIL = 30;
	localparam int PRESSURE_AT = 50;
	localparam int PRESSURE_OPS = 6;
	// Long enough for two full-table allocations to finish behind a held result.
	localparam int HOLD_CYCLES = 2 * N_ENTRIES + 100;
	// The drain is sized to outlast a full-table allocate or walk.
	localparam int DRAIN_CYCLES = N_ENTRIES + 100;
	localparam int MAX_REPORTS = 10;
	// The slowest correct run (clearing pass, every operation at full-table cost, every gap
	// and stall at its longest) stays under 3 ms; the limit allows about five times that.
	localparam longint LIMIT_NS = 64'd15_000_000;

	// One row of the directed table; res is only meaningful when typed is set.
	typedef struct packed {
		logic cmd;
		logic [SIZE_W-1:0] size;
		logic [START_W-1:0] start;
		logic typed;
		fcca_res_t res;
	} op_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	logic command;
	logic [SIZE_W-1:0] size_bytes;
	logic [START_W-1:0] start_cluster;
	logic rsp_valid;
	logic rsp_ready;
	logic status;
	logic signed [LINK_W-1:0] first_cluster;
	logic [CNT_W-1:0] clusters_free;

	// Mirror of the allocation table and free count, advanced once per accepted transaction.
	logic [LINK_W-1:0] fat_links [N_ENTRIES];
	int fat_free_cnt;

	// Outcomes of accepted transactions, oldest first, waiting for their responses.
	fcca_res_t op_outcomes_q [$];
	// First clusters of chains allocated so far, used to issue well-formed frees.
	int live_heads [$];
	op_row_t dir_rows [$];

	int bad_count = 0;
	int rsp_count = 0;
	int n_alloc = 0;
	int n_refused = 0;
	int n_empty = 0;
	int n_free = 0;

	bit cmd_gaps_on = 1'b1;
	bit rsp_gaps_on = 1'b1;
	int rsp_hold_cycles = 0;

	fat_cluster_chain_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.command(command),
		.size_bytes(size_bytes),
		.start_cluster(start_cluster),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.first_cluster(first_cluster),
		.clusters_free(clusters_free)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Applies one command to the mirror and returns the response the block must give.
	// Allocation is first fit in ascending order from entry 1; a free walks the chain and
	// stops at the reserved entry, at a free entry, at the end marker, on a link past the
	// table, or after N_ENTRIES steps.
	function automatic fcca_res_t run_fat_op(logic cmd, logic [SIZE_W-1:0] size,
			logic [START_W-1:0] start);
		fcca_res_t r;
		int need;
		int idx;
		int prev;
		int cur;
		int steps;
		bit linked;
		logic [LINK_W-1:0] nxt;
		r.status = STAT_DONE;
		r.first_cluster = END_MARK;
		if (cmd == CMD_ALLOC) begin
			need = (int'(size) + BYTES_PER_CLUSTER - 1) / BYTES_PER_CLUSTER;
			if (need > fat_free_cnt) begin
				r.status = STAT_NO_SPACE;
			end else if (need > 0) begin
				linked = 1'b0;
				prev = 0;
				for (idx = 1; idx < N_ENTRIES && need > 0; idx++) begin
					if (fat_links[idx] == FREE_LINK) begin
						fat_links[idx] = END_MARK;
						if (linked)
							fat_links[prev] = LINK_W'(idx);
						else
							r.first_cluster = LINK_W'(idx);
						prev = idx;
						linked = 1'b1;
						need--;
						fat_free_cnt--;
					end
				end
			end
		end else begin
			cur = int'(start);
			for (steps = 0; steps < N_ENTRIES; steps++) begin
				if (cur == 0 || cur >= N_ENTRIES)
					break;
				nxt = fat_links[cur];
				if (nxt == FREE_LINK)
					break;
				fat_links[cur] = FREE_LINK;
				fat_free_cnt++;
				if (nxt == END_MARK)
					break;
				cur = int'(nxt);
			end
		end
		r.clusters_free = CNT_W'(fat_free_cnt);
		return r;
	endfunction

	function automatic void add_row(logic cmd, int size, int start, logic typed,
			logic st, logic [LINK_W-1:0] fc, int fr);
		op_row_t row;
		row.cmd = cmd;
		row.size = SIZE_W'(size);
		row.start = START_W'(start);
		row.typed = typed;
		row.res.status = st;
		row.res.first_cluster = fc;
		row.res.clusters_free = CNT_W'(fr);
		dir_rows = {dir_rows, row};
	endfunction

	// Offers one transaction, holding it until accepted, then queues its outcome. Called at a
	// rising edge; cmd_valid gets at most one assignment in any time step.
	task automatic send_op(input op_row_t row);
		int gap;
		fcca_res_t got;
		fcca_res_t exp_res;
		gap = 0;
		if (cmd_gaps_on && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 15);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= row.cmd;
		size_bytes <= row.size;
		start_cluster <= row.start;
		do @(posedge clk); while (!cmd_ready);
		got = run_fat_op(row.cmd, row.size, row.start);
		exp_res = row.typed ? row.res : got;
		op_outcomes_q = {op_outcomes_q, exp_res};
		if (row.cmd == CMD_FREE) begin
			n_free++;
		end else begin
			n_alloc++;
			if (got.status == STAT_NO_SPACE)
				n_refused++;
			else if (got.first_cluster == END_MARK)
				n_empty++;
			else
				live_heads = {live_heads, int'(got.first_cluster)};
		end
	endtask

	// Output side: random stalls in bursts, plus one long hold-off on request. Each pass of
	// the loop makes at most one assignment to rsp_ready per rising edge.
	initial begin : rsp_side
		int burst;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_cycles > 0) begin
				rsp_ready <= 1'b0;
				repeat (rsp_hold_cycles) @(posedge clk);
				rsp_hold_cycles = 0;
			end else if (rsp_gaps_on && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 15);
				rsp_ready <= 1'b0;
				repeat (burst) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Every response transaction is matched against the oldest queued outcome.
	always @(posedge clk) begin : rsp_check
		fcca_res_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_count++;
			if (op_outcomes_q.size() == 0) begin
				bad_count++;
				if (bad_count <= MAX_REPORTS)
					$display("%0t: response with no command outstanding: st=%0d fc=%0d free=%0d",
						$realtime, status, first_cluster, clusters_free);
			end else begin
				want = op_outcomes_q.pop_front();
				if (status !== want.status || first_cluster !== want.first_cluster ||
						clusters_free !== want.clusters_free) begin
					bad_count++;
					if (bad_count <= MAX_REPORTS)
						$display("%0t: mismatch: expected st=%0d fc=%0d free=%0d, got st=%0d fc=%0d free=%0d",
							$realtime, want.status, $signed(want.first_cluster),
							want.clusters_free, status, first_cluster, clusters_free);
				end
			end
		end
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int i;
		int k;
		int pick;
		bit saved_gaps;
		op_row_t row;

		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		command <= CMD_ALLOC;
		size_bytes <= '0;
		start_cluster <= '0;

		for (i = 0; i < N_ENTRIES; i++)
			fat_links[i] = FREE_LINK;
		fat_links[0] = END_MARK;
		fat_free_cnt = N_ENTRIES - 1;

		// Directed table. Rows with typed set carry a response that follows straight from the
		// table contents at that point; the rest rely on the mirror.
		// Zero size claims nothing.
		add_row(CMD_ALLOC, 0, 4095, 1'b1, STAT_DONE, END_MARK, 4095);
		add_row(CMD_ALLOC, 1, 0, 1'b1, STAT_DONE, 13'd1, 4094);
		add_row(CMD_ALLOC, 512, 0, 1'b1, STAT_DONE, 13'd2, 4093);
		// One byte over a cluster takes two clusters.
		add_row(CMD_ALLOC, 513, 0, 1'b1, STAT_DONE, 13'd3, 4091);
		// The reserved entry cannot be freed.
		add_row(CMD_FREE, 4194303, 0, 1'b1, STAT_DONE, END_MARK, 4091);
		add_row(CMD_FREE, 0, 2, 1'b1, STAT_DONE, END_MARK, 4092);
		// The freed hole at 2 is reused, then the scan skips 3 and 4.
		add_row(CMD_ALLOC, 1024, 0, 1'b0, STAT_DONE, END_MARK, 0);
		// A walk that starts on a free entry touches nothing.
		add_row(CMD_FREE, 0, 4095, 1'b1, STAT_DONE, END_MARK, 4090);
		// Not enough free clusters: largest size field, then one cluster past the table.
		add_row(CMD_ALLOC, 4194303, 0, 1'b1, STAT_NO_SPACE, END_MARK, 4090);
		add_row(CMD_ALLOC, 2097152, 4095, 1'b1, STAT_NO_SPACE, END_MARK, 4090);
		add_row(CMD_FREE, 0, 1, 1'b1, STAT_DONE, END_MARK, 4091);
		add_row(CMD_FREE, 0, 3, 1'b1, STAT_DONE, END_MARK, 4093);
		add_row(CMD_FREE, 0, 2, 1'b1, STAT_DONE, END_MARK, 4095);
		// Fill the whole table with one chain, then ask for one more cluster.
		add_row(CMD_ALLOC, 2096640, 0, 1'b1, STAT_DONE, 13'd1, 0);
		add_row(CMD_ALLOC, 1, 0, 1'b1, STAT_NO_SPACE, END_MARK, 0);
		// Cut the chain in the middle; entry 1999 keeps pointing at 2000, which is then
		// reused as a one-cluster chain, so the walk from 1 runs into it and stops there.
		add_row(CMD_FREE, 0, 2000, 1'b0, STAT_DONE, END_MARK, 0);
		add_row(CMD_ALLOC, 512, 0, 1'b0, STAT_DONE, END_MARK, 0);
		add_row(CMD_FREE, 0, 1, 1'b0, STAT_DONE, END_MARK, 0);
		add_row(CMD_ALLOC, 2097152, 0, 1'b1, STAT_NO_SPACE, END_MARK, 4095);
		// A full-length chain, walked end to end.
		add_row(CMD_ALLOC, 2096640, 4095, 1'b1, STAT_DONE, 13'd1, 0);
		add_row(CMD_FREE, 4194303, 1, 1'b1, STAT_DONE, END_MARK, 4095);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cmd_ready stays low through the clearing pass, so the first send just waits.
		foreach (dir_rows[i])
			send_op(dir_rows[i]);

		// Random part: mostly small allocations and frees of live chains, with zero sizes,
		// huge sizes and frees from arbitrary clusters mixed in as noise.
		for (i = 0; i < RANDOM_OPS; i++) begin
			if (i == RANDOM_OPS - QUIET_TAIL) begin
				cmd_gaps_on = 1'b0;
				rsp_gaps_on = 1'b0;
			end
			if (i == PRESSURE_AT) begin
				// Let everything drain, then hold the output off while the input keeps
				// offering, so the result register fills and cmd_ready drops.
				cmd_valid <= 1'b0;
				do @(posedge clk); while (op_outcomes_q.size() != 0);
				saved_gaps = cmd_gaps_on;
				cmd_gaps_on = 1'b0;
				rsp_hold_cycles = HOLD_CYCLES;
				for (k = 0; k < PRESSURE_OPS; k++) begin
					row = '0;
					row.cmd = CMD_ALLOC;
					row.size = SIZE_W'($urandom_range(1, 4 * BYTES_PER_CLUSTER));
					row.start = START_W'($urandom());
					send_op(row);
				end
				cmd_gaps_on = saved_gaps;
			end
			row = '0;
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				row.cmd = CMD_ALLOC;
				row.start = START_W'($urandom());
				if (pick < 60)
					row.size = SIZE_W'($urandom_range(1, 8 * BYTES_PER_CLUSTER));
				else if (pick < 65)
					row.size = '0;
				else
					row.size = SIZE_W'($urandom());
			end else begin
				row.cmd = CMD_FREE;
				row.size = SIZE_W'($urandom());
				if (pick < 92 && live_heads.size() > 0) begin
					k = $urandom_range(0, live_heads.size() - 1);
					row.start = START_W'(live_heads[k]);
					live_heads.delete(k);
				end else begin
					row.start = START_W'($urandom());
				end
			end
			send_op(row);
		end

		cmd_valid <= 1'b0;
		while (op_outcomes_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d allocations (%0d refused, %0d of zero size) and %0d frees.",
			n_alloc, n_refused, n_empty, n_free);
		$display("%0d responses compared; output held off once for %0d cycles; %0d errors.",
			rsp_count, HOLD_CYCLES, bad_count);
		if (bad_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/fcca_pkg.sv
sv/fcca_ram.sv
sv/fcca_ctrl.sv
sv/fat_cluster_chain_allocator.sv
test/tb_top.sv
